// ===== rtl/c8h74_pkg.sv =====
// Package for the CRC-8 / Hamming(7,4) two-layer codec.
// Holds command codes, result types and the CRC and Hamming helper functions.
// No dependencies.
package c8h74_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned CRC_W   = 8;
    localparam int unsigned MSG_W   = DATA_W + CRC_W;
    localparam int unsigned NIBBLES = MSG_W / 4;
    localparam int unsigned CW_W    = NIBBLES * 7;

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              crc_error;
    } t_dec_res;

    // Bit to flip for each syndrome, 0 = leftmost bit of the 7-bit word.
    localparam logic [2:0] FLIP_POS [8] = '{3'd0, 3'd6, 3'd5, 3'd3,
                                            3'd4, 3'd0, 3'd1, 3'd2};

    // x^(k+8) mod P: CRC contribution of message bit k (bit 0 = last bit fed).
    function automatic logic [CRC_W-1:0] crc8_col(input int unsigned k);
        logic [CRC_W-1:0] r;
        int unsigned      i;
        r = 8'h01;
        for (i = 0; i < k + CRC_W; i++) begin
            r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // d0 in bit 3 -> d0 d1 d2 d3 p0 p1 p2 (d0 in bit 6).
    function automatic logic [6:0] ham_enc(input logic [3:0] n);
        logic p0, p1, p2;
        p0 = n[3] ^ n[2] ^ n[1];
        p1 = n[2] ^ n[1] ^ n[0];
        p2 = n[3] ^ n[1] ^ n[0];
        return {n, p0, p1, p2};
    endfunction

    function automatic logic [3:0] ham_dec(input logic [6:0] w);
        logic [2:0] syn;
        logic [6:0] flip;
        syn[2] = w[6] ^ w[5] ^ w[4] ^ w[2];
        syn[1] = w[5] ^ w[4] ^ w[3] ^ w[1];
        syn[0] = w[6] ^ w[4] ^ w[3] ^ w[0];
        flip   = (syn != 3'd0) ? (7'b1000000 >> FLIP_POS[syn]) : 7'd0;
        return w[6:3] ^ flip[6:3];
    endfunction

endpackage

// ===== rtl/c8h74_if.sv =====
// Valid/ready channel interfaces for the codec input and result transfers.
// Depends on c8h74_pkg for field widths.
interface c8h74_in_if import c8h74_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [DATA_W-1:0] data_word;
    logic [CW_W-1:0]   received_codeword;

    modport source (output valid, command, data_word, received_codeword, input ready);
    modport sink   (input valid, command, data_word, received_codeword, output ready);
endinterface

interface c8h74_out_if import c8h74_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CW_W-1:0]   encoded_codeword;
    logic [DATA_W-1:0] decoded_data;
    logic              crc_error;

    modport source (output valid, encoded_codeword, decoded_data, crc_error, input ready);
    modport sink   (input valid, encoded_codeword, decoded_data, crc_error, output ready);
endinterface

// ===== rtl/crc8_hamming74_two_layer_codec.sv =====
// CRC-8 + Hamming(7,4) codec top: input register, XOR network, result register.
// An input transfer loads the input register; the result register takes its result once it is free.
// Throughput: one item per cycle while o_out.ready holds; one combinational encode/decode stage sets it.
// Reset (i_rst_n, synchronous, active low) clears both stage valid flags only.
// Depends on c8h74_pkg, c8h74_if, c8h74_enc, c8h74_dec.
module crc8_hamming74_two_layer_codec import c8h74_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    c8h74_in_if.sink           i_in,
    c8h74_out_if.source        o_out
);

    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [DATA_W-1:0] r_s1_data;
    logic [CW_W-1:0]   r_s1_cw;

    logic              r_s2_valid;
    logic [CW_W-1:0]   r_s2_enc;
    logic [DATA_W-1:0] r_s2_dec;
    logic              r_s2_err;

    logic              w_s2_free;
    logic              w_s1_adv;
    logic [CW_W-1:0]   w_enc_cw;
    t_dec_res          w_dec;
    logic              n_is_dec;

    assign w_s2_free  = !r_s2_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign i_in.ready = !r_s1_valid || w_s2_free;
    assign n_is_dec   = (t_cmd'(r_s1_cmd) == CMD_DECODE);

    c8h74_enc u_enc (
        .i_data     (r_s1_data),
        .o_codeword (w_enc_cw)
    );

    c8h74_dec u_dec (
        .i_codeword (r_s1_cw),
        .o_res      (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_cmd  <= i_in.command;
            r_s1_data <= i_in.data_word;
            r_s1_cw   <= i_in.received_codeword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_s1_adv) begin
            r_s2_enc <= n_is_dec ? '0 : w_enc_cw;
            r_s2_dec <= n_is_dec ? w_dec.data : '0;
            r_s2_err <= n_is_dec ? w_dec.crc_error : 1'b0;
        end
    end

    assign o_out.valid            = r_s2_valid;
    assign o_out.encoded_codeword = r_s2_enc;
    assign o_out.decoded_data     = r_s2_dec;
    assign o_out.crc_error        = r_s2_err;

`ifndef SYNTHESIS
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_err) |-> (r_s2_dec == '0))
        else $error("decoded data not cleared on CRC error");

    a_one_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> ((r_s2_enc == '0) || ((r_s2_dec == '0) && !r_s2_err)))
        else $error("encode and decode fields both set");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_free) |=> (r_s1_valid && $stable(r_s1_cw)
                                         && $stable(r_s1_data)))
        else $error("input stage lost item while result stalled");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s2_valid |-> i_in.ready)
        else $error("input not ready with empty result register");
`endif

endmodule

// ===== rtl/c8h74_enc.sv =====
// Encoder: appends CRC-8 to 16 data bits and maps six nibbles to Hamming(7,4).
// Depends on c8h74_pkg.
module c8h74_enc import c8h74_pkg::*; (
    input  logic [DATA_W-1:0] i_data,
    output logic [CW_W-1:0]   o_codeword
);

    logic [CRC_W-1:0] w_crc;
    logic [MSG_W-1:0] w_msg;

    always_comb begin
        w_crc = '0;
        for (int k = 0; k < DATA_W; k++) begin
            w_crc = w_crc ^ ({CRC_W{i_data[k]}} & crc8_col(k));
        end
    end

    assign w_msg = {i_data, w_crc};

    for (genvar g = 0; g < NIBBLES; g++) begin : g_nib
        assign o_codeword[7*g +: 7] = ham_enc(w_msg[4*g +: 4]);
    end

endmodule

// ===== rtl/c8h74_dec.sv =====
// Decoder: corrects one bit per 7-bit word, rebuilds 24 bits, checks CRC-8.
// Depends on c8h74_pkg.
module c8h74_dec import c8h74_pkg::*; (
    input  logic [CW_W-1:0] i_codeword,
    output t_dec_res        o_res
);

    logic [MSG_W-1:0] w_msg;
    logic [CRC_W-1:0] w_rem;

    for (genvar g = 0; g < NIBBLES; g++) begin : g_word
        assign w_msg[4*g +: 4] = ham_dec(i_codeword[7*g +: 7]);
    end

    always_comb begin
        w_rem = '0;
        for (int k = 0; k < MSG_W; k++) begin
            w_rem = w_rem ^ ({CRC_W{w_msg[k]}} & crc8_col(k));
        end
    end

    assign o_res.crc_error = (w_rem != '0);
    assign o_res.data      = o_res.crc_error ? '0 : w_msg[MSG_W-1 -: DATA_W];

endmodule
